// ===== sv/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types, constants and helpers of the marker frame sequencer.
// ----------------------------------------------------------------------------
package mfs_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_FRAME_ROWS = 2'd0;
	localparam logic [1:0] REG_FRAME_COLS = 2'd1;
	localparam logic [1:0] REG_THRESHOLD  = 2'd2;
	localparam logic [1:0] REG_KEEP_INTV  = 2'd3;

	localparam int CFG_DATA_BITS = 13;

	// reset values of the registers
	localparam logic [12:0] RST_FRAME_ROWS = 13'd1080;
	localparam logic [12:0] RST_FRAME_COLS = 13'd1920;
	localparam logic [7:0]  RST_THRESHOLD  = 8'd180;
	localparam logic [3:0]  RST_KEEP_INTV  = 4'd3;

	// probe geometry
	localparam int PROBE_COUNT  = 20;
	localparam int PROBE_STEP   = 20;
	localparam int PROBE_OFFSET = 200;
	localparam int PROBE_SPAN   = PROBE_COUNT * PROBE_STEP;

	// gray weights, sum of 30b+59g+11r fits in 15 bits
	localparam int SUM_BITS = 15;
	localparam logic [SUM_BITS-1:0] W_BLUE  = 15'd30;
	localparam logic [SUM_BITS-1:0] W_GREEN = 15'd59;
	localparam logic [SUM_BITS-1:0] W_RED   = 15'd11;
	localparam logic [SUM_BITS-1:0] GRAY_DIV = 15'd100;

	localparam logic [15:0] KEPT_MAX = 16'hFFFF;

	// frame-end queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// encoded phase values on the result
	localparam logic [1:0] PHASE_SEEK  = 2'd0;
	localparam logic [1:0] PHASE_START = 2'd1;
	localparam logic [1:0] PHASE_DATA  = 2'd2;
	localparam logic [1:0] PHASE_END   = 2'd3;

	typedef enum logic [3:0] {
		PH_SEEK  = 4'b0001,
		PH_START = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_END   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [12:0] frame_rows;
		logic [12:0] frame_cols;
		logic [7:0]  bright_threshold;
		logic [3:0]  keep_interval;
	} cfg_t;

	// queue handshake toward the back end
	typedef struct packed {
		logic valid;
		logic bright;
	} frame_ev_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		code = PHASE_SEEK;
		unique case (ph)
			PH_SEEK:  code = PHASE_SEEK;
			PH_START: code = PHASE_START;
			PH_DATA:  code = PHASE_DATA;
			PH_END:   code = PHASE_END;
			default:  code = PHASE_SEEK;
		endcase
		return code;
	endfunction

	// true when a quarter-offset below 100 is a multiple of five
	function automatic logic is_mult5(input logic [6:0] q);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < PROBE_COUNT; k++) begin
			if (q == 7'(k * 5)) hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ===== sv/marker_frame_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// marker_frame_sequencer_core
// Pixel-stream frame classifier and marker-delimited frame selector.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled, and gives one result per frame end
// pixel. A pixel crosses a one-stage front end (gray sum and probe test);
// the frame-end result then passes a four-entry event queue and the phase
// machine, which registers it. Pixels never wait on the output side
// directly; the input stalls only while a frame-end pixel sits in the front
// stage and the event queue is full. Configuration may be written while no
// frame-end result is pending.
module marker_frame_sequencer_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [12:0]           cfg_data,
	// pixel channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            blue,
	input  logic [7:0]            green,
	input  logic [7:0]            red,
	input  logic [COORD_BITS-1:0] pixel_row,
	input  logic [COORD_BITS-1:0] pixel_col,
	input  logic                  frame_end,
	// frame result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  frame_bright,
	output logic [1:0]            phase_now,
	output logic                  keep_frame,
	output logic [15:0]           picture_number
);

	mfs_pkg::cfg_t      cfg_q;
	mfs_pkg::frame_ev_t push_ev;
	mfs_pkg::frame_ev_t head;
	logic               q_full;
	logic               pop;

	// configuration registers, each write takes effect on the next clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_rows       <= mfs_pkg::RST_FRAME_ROWS;
			cfg_q.frame_cols       <= mfs_pkg::RST_FRAME_COLS;
			cfg_q.bright_threshold <= mfs_pkg::RST_THRESHOLD;
			cfg_q.keep_interval    <= mfs_pkg::RST_KEEP_INTV;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mfs_pkg::REG_FRAME_ROWS: cfg_q.frame_rows       <= cfg_data;
				mfs_pkg::REG_FRAME_COLS: cfg_q.frame_cols       <= cfg_data;
				mfs_pkg::REG_THRESHOLD:  cfg_q.bright_threshold <= cfg_data[7:0];
				mfs_pkg::REG_KEEP_INTV:  cfg_q.keep_interval    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// front end: per-pixel probe test and frame flag
	mfs_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.pixel_row (pixel_row),
		.pixel_col (pixel_col),
		.frame_end (frame_end),
		.q_full    (q_full),
		.ev        (push_ev)
	);

	// frame-end events decouple the two halves
	mfs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_ev (push_ev),
		.full    (q_full),
		.pop     (pop),
		.head    (head)
	);

	// back end: phase machine, decimation and picture index
	mfs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_bright   (frame_bright),
		.phase_now      (phase_now),
		.keep_frame     (keep_frame),
		.picture_number (picture_number)
	);

endmodule

// ===== sv/mfs_front.sv =====
// ----------------------------------------------------------------------------
// mfs_front
// Accepts pixels, computes the gray sum and probe test, keeps the frame
// flag and posts one bright/dark event per frame end.
// ----------------------------------------------------------------------------
module mfs_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mfs_pkg::cfg_t         cfg,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            blue,
	input  logic [7:0]            green,
	input  logic [7:0]            red,
	input  logic [COORD_BITS-1:0] pixel_row,
	input  logic [COORD_BITS-1:0] pixel_col,
	input  logic                  frame_end,
	input  logic                  q_full,
	output mfs_pkg::frame_ev_t    ev
);

	localparam int RW = (COORD_BITS > 12) ? COORD_BITS : 12;
	localparam int DW = RW + 2;

	logic                          valid_s1;
	logic                          probe_s1;
	logic                          end_s1;
	logic [mfs_pkg::SUM_BITS-1:0]  sum_s1;
	logic                          flag_q;

	logic signed [DW-1:0]          col_d;
	logic                          row_hit;
	logic                          probe;
	logic [mfs_pkg::SUM_BITS-1:0]  sum;
	logic [mfs_pkg::SUM_BITS-1:0]  limit;
	logic                          fail;
	logic                          advance;

	// offset of this column from the first probe column
	assign col_d = $signed(DW'(pixel_col)) + $signed(DW'(mfs_pkg::PROBE_OFFSET))
		- $signed(DW'(cfg.frame_cols[12:1]));
	assign row_hit = (RW'(pixel_row) == RW'(cfg.frame_rows[12:1]));
	assign probe = row_hit && (col_d >= 0) && (col_d < DW'(mfs_pkg::PROBE_SPAN))
		&& (col_d[1:0] == 2'b00) && mfs_pkg::is_mult5(col_d[8:2]);

	assign sum = mfs_pkg::W_BLUE * mfs_pkg::SUM_BITS'(blue)
		+ mfs_pkg::W_GREEN * mfs_pkg::SUM_BITS'(green)
		+ mfs_pkg::W_RED * mfs_pkg::SUM_BITS'(red);

	// gray > thr  <=>  sum >= 100 * (thr + 1)
	assign limit = (mfs_pkg::SUM_BITS'(cfg.bright_threshold) + 15'd1) * mfs_pkg::GRAY_DIV;
	assign fail  = probe_s1 && (sum_s1 < limit);

	assign advance  = !valid_s1 || !end_s1 || !q_full;
	assign in_stall = !advance;

	assign ev.valid  = valid_s1 && end_s1 && !q_full;
	assign ev.bright = flag_q && !fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flag_q   <= 1'b1;
		end else begin
			if (advance) valid_s1 <= in_valid;
			if (valid_s1 && advance) begin
				if (end_s1) flag_q <= 1'b1;
				else if (fail) flag_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			sum_s1   <= sum;
			probe_s1 <= probe;
			end_s1   <= frame_end;
		end
	end

endmodule

// ===== sv/mfs_queue.sv =====
// ----------------------------------------------------------------------------
// mfs_queue
// Short queue of frame-end events between the front and back ends.
// ----------------------------------------------------------------------------
module mfs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  mfs_pkg::frame_ev_t push_ev,
	output logic               full,
	input  logic               pop,
	output mfs_pkg::frame_ev_t head
);

	localparam int PB = mfs_pkg::QPTR_BITS;

	logic [mfs_pkg::QUEUE_DEPTH-1:0] mem_q;
	logic [PB-1:0]                   wr_q;
	logic [PB-1:0]                   rd_q;
	logic [PB:0]                     cnt_q;
	logic                            do_pop;

	assign full       = (cnt_q == (PB+1)'(mfs_pkg::QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.bright = mem_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ev.valid) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (push_ev.valid && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push_ev.valid && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ev.valid) mem_q[wr_q] <= push_ev.bright;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_ev.valid && full)) else $error("push into full queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PB+1)'(mfs_pkg::QUEUE_DEPTH)) else $error("queue count out of range");
	a_pop_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !push_ev.valid) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("pop did not drain an entry");
`endif

endmodule

// ===== sv/mfs_back.sv =====
// ----------------------------------------------------------------------------
// mfs_back
// Phase machine run once per frame end, with the result register.
// ----------------------------------------------------------------------------
module mfs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  mfs_pkg::cfg_t      cfg,
	input  mfs_pkg::frame_ev_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               frame_bright,
	output logic [1:0]         phase_now,
	output logic               keep_frame,
	output logic [15:0]        picture_number
);

	mfs_pkg::phase_t phase_q, phase_d;
	logic [3:0]  dec_q, dec_d, dec_inc;
	logic [15:0] kept_q, kept_d;
	logic        keep_d;
	logic [15:0] pic_d;
	logic        out_valid_q;
	logic        bright_q, keep_q;
	logic [1:0]  phase_out_q;
	logic [15:0] pic_q;

	assign pop = head.valid && (!out_valid_q || !out_stall);
	assign dec_inc = dec_q + 4'd1;

	always_comb begin
		phase_d = phase_q;
		dec_d   = dec_q;
		kept_d  = kept_q;
		keep_d  = 1'b0;
		pic_d   = '0;
		unique case (phase_q)
			mfs_pkg::PH_SEEK: begin
				if (head.bright) phase_d = mfs_pkg::PH_START;
			end
			mfs_pkg::PH_START: begin
				if (!head.bright) begin
					phase_d = mfs_pkg::PH_DATA;
					dec_d   = '0;
				end
			end
			mfs_pkg::PH_DATA: begin
				if (head.bright) begin
					phase_d = mfs_pkg::PH_END;
				end else begin
					if (dec_q == '0) begin
						keep_d = 1'b1;
						pic_d  = kept_q;
						if (kept_q != mfs_pkg::KEPT_MAX) kept_d = kept_q + 16'd1;
					end
					// zero interval behaves as one
					dec_d = (dec_inc >= cfg.keep_interval) ? 4'd0 : dec_inc;
				end
			end
			mfs_pkg::PH_END: phase_d = mfs_pkg::PH_END;
			default: phase_d = mfs_pkg::PH_END;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mfs_pkg::PH_SEEK;
			dec_q       <= '0;
			kept_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				dec_q   <= dec_d;
				kept_q  <= kept_d;
			end
			if (pop) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bright_q    <= head.bright;
			phase_out_q <= mfs_pkg::phase_code(phase_d);
			keep_q      <= keep_d;
			pic_q       <= pic_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_bright   = bright_q;
	assign phase_now      = phase_out_q;
	assign keep_frame     = keep_q;
	assign picture_number = pic_q;

`ifndef SYNTHESIS
	a_keep_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && keep_q) |-> (phase_out_q == mfs_pkg::PHASE_DATA))
		else $error("kept frame outside data phase");
	a_pic_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !keep_q) |-> (pic_q == '0))
		else $error("picture number on dropped frame");
	a_end_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && phase_q == mfs_pkg::PH_END) |=> (phase_out_q == mfs_pkg::PHASE_END))
		else $error("left ended phase");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for marker_frame_sequencer_core.
// ----------------------------------------------------------------------------
// Sends short synthetic frames made of probe pixels, near misses and noise,
// ending each with a frame-end pixel, and walks the phase machine once
// through seek, start marker, a long data stretch under several settings and
// the closing marker. A scoreboard predicts each frame result from its own
// copy of the state and configuration and checks the result stream field by
// field. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
	import mfs_pkg::*;

	localparam int COORD_BITS      = 12;
	localparam int RESET_CYCLES    = 8;
	localparam int SETTLE_CYCLES   = 8;
	localparam int GAP_MAX         = 6;
	localparam int WATCHDOG_LIMIT  = 2000;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct packed {
		rgb_t                  color;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
		logic                  fin;
	} pixel_t;

	typedef struct packed {
		logic        bright;
		logic [1:0]  phase;
		logic        keep;
		logic [15:0] picture;
	} frame_result_t;

	typedef enum int {RX_READY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

	// predicts one result per frame-end pixel and checks results in order
	class frame_scoreboard;
		cfg_t          cfg;
		logic [1:0]    phase;
		bit            all_bright;
		logic [3:0]    decim;
		logic [15:0]   kept;
		frame_result_t expected_frames[$];
		int            errors;
		int            pixels;
		int            results;
		int            kept_results;

		function new();
			cfg.frame_rows       = RST_FRAME_ROWS;
			cfg.frame_cols       = RST_FRAME_COLS;
			cfg.bright_threshold = RST_THRESHOLD;
			cfg.keep_interval    = RST_KEEP_INTV;
			phase      = PHASE_SEEK;
			all_bright = 1'b1;
			decim      = '0;
			kept       = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [12:0] val);
			case (idx)
				REG_FRAME_ROWS: cfg.frame_rows       = val;
				REG_FRAME_COLS: cfg.frame_cols       = val;
				REG_THRESHOLD:  cfg.bright_threshold = val[7:0];
				REG_KEEP_INTV:  cfg.keep_interval    = val[3:0];
				default: ;
			endcase
		endfunction

		function int gray_level(rgb_t c);
			return (int'(W_BLUE) * int'(c.blue) + int'(W_GREEN) * int'(c.green)
				+ int'(W_RED) * int'(c.red)) / int'(GRAY_DIV);
		endfunction

		// probe grid: PROBE_COUNT columns from half width minus the offset
		function bit probe_hit(logic [COORD_BITS-1:0] row, logic [COORD_BITS-1:0] col);
			int d;
			d = int'(col) - (int'(cfg.frame_cols >> 1) - PROBE_OFFSET);
			return int'(row) == int'(cfg.frame_rows >> 1) && d >= 0 && d < PROBE_SPAN
				&& d % PROBE_STEP == 0;
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function void note_pixel(pixel_t px);
			frame_result_t res;
			pixels++;
			if (probe_hit(px.row, px.col) && gray_level(px.color) <= int'(cfg.bright_threshold))
				all_bright = 1'b0;
			if (!px.fin)
				return;
			res = '0;
			res.bright = all_bright;
			all_bright = 1'b1;
			case (phase)
				PHASE_SEEK: begin
					if (res.bright)
						phase = PHASE_START;
				end
				PHASE_START: begin
					if (!res.bright) begin
						phase = PHASE_DATA;
						decim = '0;
					end
				end
				PHASE_DATA: begin
					if (res.bright) begin
						phase = PHASE_END;
					end else begin
						if (decim == '0) begin
							res.keep    = 1'b1;
							res.picture = kept;
							if (kept != KEPT_MAX)
								kept++;
						end
						decim = decim + 4'd1;
						if (decim >= cfg.keep_interval)
							decim = '0;
					end
				end
				default: phase = PHASE_END;
			endcase
			res.phase = phase;
			expected_frames.push_back(res);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (expected_frames.size() == 0) begin
				$error("unexpected frame result: bright %0d phase %0d keep %0d picture %0d",
					got.bright, got.phase, got.keep, got.picture);
				errors++;
				return;
			end
			want = expected_frames.pop_front();
			results++;
			if (want.keep)
				kept_results++;
			if ($isunknown(got)) begin
				$error("frame result carries unknown bits: %h", got);
				errors++;
			end
			compare_field("frame_bright", want.bright, got.bright);
			compare_field("phase_now", want.phase, got.phase);
			compare_field("keep_frame", want.keep, got.keep);
			compare_field("picture_number", want.picture, got.picture);
		endfunction
	endclass

	// clock, reset and every block input start known
	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  cfg_write      = 1'b0;
	logic [1:0]            cfg_index      = REG_FRAME_ROWS;
	logic [12:0]           cfg_data       = '0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic [7:0]            blue           = '0;
	logic [7:0]            green          = '0;
	logic [7:0]            red            = '0;
	logic [COORD_BITS-1:0] pixel_row      = '0;
	logic [COORD_BITS-1:0] pixel_col      = '0;
	logic                  frame_end      = 1'b0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic                  frame_bright;
	logic [1:0]            phase_now;
	logic                  keep_frame;
	logic [15:0]           picture_number;

	frame_scoreboard sb = new();

	// sender burst state
	int burst_left = 0;
	int burst_max  = 40;

	// receiver stall pattern state
	rx_mode_e rx_mode   = RX_READY;
	int       mode_left = 0;
	int       rx_cycle  = 0;

	always #2 clk = ~clk;

	marker_frame_sequencer_core #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk,
		.arst_n,
		.cfg_write,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_stall,
		.blue,
		.green,
		.red,
		.pixel_row,
		.pixel_col,
		.frame_end,
		.out_valid,
		.out_stall,
		.frame_bright,
		.phase_now,
		.keep_frame,
		.picture_number
	);

	// result side: check the accepted transaction, then pick the next stall
	always @(posedge clk) begin
		frame_result_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.bright  = frame_bright;
			seen.phase   = phase_now;
			seen.keep    = keep_frame;
			seen.picture = picture_number;
			sb.check_result(seen);
		end
		rx_cycle++;
		if (mode_left == 0) begin
			rx_mode   = rx_mode_e'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 300);
		end else begin
			mode_left--;
		end
		case (rx_mode)
			RX_READY:    out_stall <= 1'b0;
			RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= (rx_cycle % 5 < 2);
		endcase
	end

	// give up once no transaction has moved on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("** marker_frame_sequencer_core: FAILED **");
		$finish;
	end

	function automatic int probe_row();
		return int'(sb.cfg.frame_rows >> 1);
	endfunction

	function automatic int probe_col(int k);
		return int'(sb.cfg.frame_cols >> 1) - PROBE_OFFSET + k * PROBE_STEP;
	endfunction

	// probe columns left of zero never arrive on a narrow frame
	function automatic int any_probe_k();
		int k;
		do
			k = $urandom_range(0, PROBE_COUNT - 1);
		while (probe_col(k) < 0);
		return k;
	endfunction

	function automatic pixel_t pix(int b, int g, int r, int row, int col, bit fin);
		pixel_t p;
		p.color.blue  = 8'(b);
		p.color.green = 8'(g);
		p.color.red   = 8'(r);
		p.row         = COORD_BITS'(row);
		p.col         = COORD_BITS'(col);
		p.fin         = fin;
		return p;
	endfunction

	// all three components at or below the threshold keep the weighted mean there
	function automatic rgb_t dark_color();
		rgb_t c;
		int   th;
		th = sb.cfg.bright_threshold;
		c  = 24'($urandom);
		if (sb.gray_level(c) > th) begin
			c.blue  = 8'($urandom_range(0, th));
			c.green = 8'($urandom_range(0, th));
			c.red   = 8'($urandom_range(0, th));
		end
		return c;
	endfunction

	// only called while the threshold is below full scale
	function automatic rgb_t bright_color();
		rgb_t c;
		int   th;
		th = sb.cfg.bright_threshold;
		c  = 24'($urandom);
		if (sb.gray_level(c) <= th) begin
			c.blue  = 8'($urandom_range(th + 1, 255));
			c.green = 8'($urandom_range(th + 1, 255));
			c.red   = 8'($urandom_range(th + 1, 255));
		end
		return c;
	endfunction

	function automatic pixel_t probe_pixel(rgb_t c);
		pixel_t p;
		p       = pix(0, 0, 0, probe_row(), probe_col(any_probe_k()), 1'b0);
		p.color = c;
		return p;
	endfunction

	// off the probe grid within a column step, past the window edge or by one row
	function automatic pixel_t near_miss_pixel();
		pixel_t p;
		int     k;
		k = any_probe_k();
		case ($urandom_range(0, 2))
			0: p = pix(0, 0, 0, probe_row(), probe_col(k) + $urandom_range(1, PROBE_STEP - 1), 0);
			1: p = pix(0, 0, 0, probe_row(),
				$urandom_range(0, 1) ? probe_col(0) - PROBE_STEP : probe_col(0) + PROBE_SPAN, 0);
			default: p = pix(0, 0, 0, $urandom_range(0, 1) ? probe_row() + 1 : probe_row() - 1,
				probe_col(k), 0);
		endcase
		p.color = 24'($urandom);
		return p;
	endfunction

	task automatic put_pixel(input pixel_t px);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
			burst_left = $urandom_range(1, burst_max);
		end
		in_valid  <= 1'b1;
		blue      <= px.color.blue;
		green     <= px.color.green;
		red       <= px.color.red;
		pixel_row <= px.row;
		pixel_col <= px.col;
		frame_end <= px.fin;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_pixel(px);
		burst_left--;
	endtask

	// a dark frame always holds one probe at or below the threshold
	task automatic send_frame(input bit dark, input int len);
		int     dark_at;
		pixel_t px;
		dark_at = $urandom_range(0, len - 1);
		for (int i = 0; i < len; i++) begin
			if (dark && i == dark_at) begin
				px = probe_pixel(dark_color());
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: px = (sb.cfg.bright_threshold != 8'hFF)
						? probe_pixel(bright_color()) : near_miss_pixel();
					9: px = pixel_t'({24'($urandom), COORD_BITS'($urandom),
						COORD_BITS'($urandom), 1'b0});
					default: px = near_miss_pixel();
				endcase
			end
			px.fin = (i == len - 1);
			put_pixel(px);
		end
	endtask

	// data phase only: every frame is dark so the sequence never closes early
	task automatic data_frames(input int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
			send_frame(1'b1, len);
			sent += len;
		end
	endtask

	task automatic settle();
		in_valid  <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic load_setting(input int rows, input int cols, input int thr, input int keep);
		write_reg(REG_FRAME_ROWS, 13'(rows));
		write_reg(REG_FRAME_COLS, 13'(cols));
		write_reg(REG_THRESHOLD, 13'(thr));
		write_reg(REG_KEEP_INTV, 13'(keep));
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int prow;
		int th;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk under reset configuration
		prow = probe_row();
		th   = sb.cfg.bright_threshold;
		// seeking: dark first probe, white end pixel off the grid
		put_pixel(pix(0, 0, 0, prow, probe_col(0), 0));
		put_pixel(pix(255, 255, 255, 0, 0, 1));
		// gray equal to the threshold is not bright
		put_pixel(pix(th, th, th, prow, probe_col(PROBE_COUNT - 1), 1));
		// start marker: edge probes bright, dark pixels just off the grid
		put_pixel(pix(th + 1, th + 1, th + 1, prow, probe_col(0), 0));
		put_pixel(pix(255, 255, 255, prow, probe_col(PROBE_COUNT - 1), 0));
		put_pixel(pix(0, 0, 0, prow, probe_col(0) - PROBE_STEP, 0));
		put_pixel(pix(0, 0, 0, prow, probe_col(0) + PROBE_SPAN, 0));
		put_pixel(pix(0, 0, 0, prow - 1, probe_col(5), 0));
		put_pixel(pix(0, 0, 0, prow, probe_col(5) + PROBE_STEP / 2, 0));
		put_pixel(pix(0, 0, 0, (1 << COORD_BITS) - 1, (1 << COORD_BITS) - 1, 1));
		// no probe arrives at all, flag stays set, marker goes on
		put_pixel(pix(0, 0, 0, prow, probe_col(3) + 1, 1));
		// marker ends on a dark frame which is dropped
		put_pixel(pix(0, 0, 255, prow, probe_col(1), 1));
		// data frames, single- and dual-channel extremes, one kept out of three
		put_pixel(pix(255, 0, 0, prow, probe_col(2), 1));
		put_pixel(pix(0, 255, 0, prow, probe_col(7), 1));
		put_pixel(pix(0, 255, 255, prow, probe_col(11), 1));
		put_pixel(pix(255, 0, 255, prow, probe_col(13), 1));
		// bright probes do not save a frame with one dark probe
		put_pixel(pix(255, 255, 255, prow, probe_col(4), 0));
		put_pixel(pix(200, 200, 200, prow, probe_col(17), 0));
		put_pixel(pix(0, 0, 0, prow, probe_col(18), 1));

		// random data stretches under several settings
		data_frames(200);
		settle();
		load_setting(2, 400, 0, 1);
		data_frames(200);
		settle();
		load_setting(4096, 4096, 255, 15);
		data_frames(200);
		settle();
		// narrow frame with a zero keep interval
		load_setting(1000, 198, 128, 0);
		data_frames(200);
		repeat (2) begin
			settle();
			load_setting($urandom_range(2, 4096), $urandom_range(400, 4096),
				$urandom_range(0, 8191), $urandom_range(0, 8191));
			data_frames(150);
		end

		// closing marker, then frames after the end of the sequence
		settle();
		load_setting(RST_FRAME_ROWS, RST_FRAME_COLS, RST_THRESHOLD, RST_KEEP_INTV);
		send_frame(1'b0, $urandom_range(1, 4));
		repeat (12) send_frame(1'($urandom_range(0, 1)), $urandom_range(1, 5));
		settle();

		$display("covered %0d pixels and %0d frame results (%0d kept) over seven settings,",
			sb.pixels, sb.results, sb.kept_results);
		$display("every phase of the sequence, narrow frames and a zero keep interval");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** marker_frame_sequencer_core: PASSED **");
		else
			$display("** marker_frame_sequencer_core: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mfs_pkg.sv
sv/mfs_front.sv
sv/mfs_queue.sv
sv/mfs_back.sv
sv/marker_frame_sequencer_core.sv
verif/testbench.sv
